/* rtl/core/cdda_pkg.sv */
`timescale 1ns / 1ps

package cdda_pkg;

	localparam int YEAR_WIDTH_DEF = 16;
	localparam int DAYS_W         = 16;
	localparam int MONTH_W        = 4;
	localparam int DAY_W          = 5;
	localparam int OUT_YEAR_W     = 16;
	localparam int CFG_DATA_W     = 16;
	localparam int CFG_INDEX_W    = 2;
	localparam int IN_TDATA_W     = 16;
	localparam int OUT_TDATA_W    = 32;
	localparam int M400_W         = 9;
	localparam int PC_W           = 4;
	localparam int QUOT_W         = 8;
	localparam int RECIP_W        = 12;

	localparam logic [CFG_INDEX_W-1:0] CFG_START_YEAR  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_MONTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_START_DAY   = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_START_YEAR  = 16'd2000;
	localparam logic [MONTH_W-1:0]    RST_START_MONTH = 4'd1;
	localparam logic [DAY_W-1:0]      RST_START_DAY   = 5'd1;

	localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
	localparam logic [DAY_W-1:0]   FEB_LEAP   = 5'd29;
	localparam logic [DAY_W-1:0]   LONG_MONTH = 5'd31;

	localparam logic [M400_W-1:0]     CENTURY   = 9'd100;
	localparam logic [M400_W-1:0]     CENTURY_2 = 9'd200;
	localparam logic [M400_W-1:0]     CENTURY_3 = 9'd300;
	localparam logic [M400_W-1:0]     CYCLE_END = 9'd399;
	localparam logic [CFG_DATA_W-1:0] CYCLE_LEN = 16'd400;
	localparam logic [M400_W-1:0]     YEAR_LEN  = 9'd365;

	// (x * RECIP_25) >> 16 equals x / 25 for any 12-bit x
	localparam logic [RECIP_W-1:0] RECIP_25 = 12'd2622;

	localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t ST_IDLE  = 4'd0;
	localparam pc_t ST_TAKE  = 4'd1;
	localparam pc_t ST_FIRST = 4'd2;
	localparam pc_t ST_YEAR  = 4'd3;
	localparam pc_t ST_MONTH = 4'd4;
	localparam pc_t ST_EMIT  = 4'd5;
	localparam pc_t ST_BACK  = 4'd6;
	localparam pc_t ST_LOAD  = 4'd7;
	localparam pc_t ST_DIV   = 4'd8;
	localparam pc_t ST_CLAMP = 4'd9;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_TAKE,
		OP_MSTEP,
		OP_YSTEP,
		OP_EMIT,
		OP_LDINIT,
		OP_DIVSTEP,
		OP_CLAMP
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_PEND,
		C_NOTAKE,
		C_FITS,
		C_NFITS,
		C_YOK,
		C_OBUSY
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ctrl_t;

	typedef struct packed {
		logic pend;
		logic take;
		logic fits;
		logic yok;
		logic obusy;
	} stat_t;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		unique case (pc)
			ST_IDLE:  w = '{OP_NONE,    C_PEND,   ST_LOAD};
			ST_TAKE:  w = '{OP_TAKE,    C_NOTAKE, ST_IDLE};
			ST_FIRST: w = '{OP_MSTEP,   C_FITS,   ST_EMIT};
			ST_YEAR:  w = '{OP_YSTEP,   C_YOK,    ST_YEAR};
			ST_MONTH: w = '{OP_MSTEP,   C_NFITS,  ST_MONTH};
			ST_EMIT:  w = '{OP_EMIT,    C_OBUSY,  ST_EMIT};
			ST_BACK:  w = '{OP_NONE,    C_ALWAYS, ST_IDLE};
			ST_LOAD:  w = '{OP_LDINIT,  C_NEVER,  ST_IDLE};
			ST_DIV:   w = '{OP_DIVSTEP, C_NEVER,  ST_IDLE};
			ST_CLAMP: w = '{OP_CLAMP,   C_ALWAYS, ST_IDLE};
			default:  w = '{OP_NONE,    C_ALWAYS, ST_IDLE};
		endcase
		return w;
	endfunction

	function automatic logic is_leap(input logic [M400_W-1:0] m400);
		return ((m400[1:0] == 2'd0) && (m400 != CENTURY) && (m400 != CENTURY_2)
			&& (m400 != CENTURY_3)) || (m400 == '0);
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		if (m == MONTH_FEB) begin
			len = leap ? FEB_LEAP : MONTH_DAYS[1];
		end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
			len = MONTH_DAYS[m - MONTH_JAN];
		end else begin
			len = LONG_MONTH;
		end
		return len;
	endfunction

endpackage

/* rtl/core/cdda_seq.sv */
`timescale 1ns / 1ps

module cdda_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  cdda_pkg::stat_t stat,
	output cdda_pkg::ctrl_t ctrl
);
	import cdda_pkg::*;

	pc_t  pc_q;
	logic jump;

	assign ctrl = ucode(pc_q);

	always_comb begin
		unique case (ctrl.cond)
			C_NEVER:  jump = 1'b0;
			C_ALWAYS: jump = 1'b1;
			C_PEND:   jump = stat.pend;
			C_NOTAKE: jump = !stat.take;
			C_FITS:   jump = stat.fits;
			C_NFITS:  jump = !stat.fits;
			C_YOK:    jump = stat.yok;
			C_OBUSY:  jump = stat.obusy;
			default:  jump = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_IDLE;
		end else begin
			pc_q <= jump ? ctrl.target : pc_q + pc_t'(1);
		end
	end

endmodule

/* rtl/core/cdda_dpath.sv */
`timescale 1ns / 1ps

module cdda_dpath #(
	parameter int YEAR_WIDTH = cdda_pkg::YEAR_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cdda_pkg::ctrl_t                     ctrl,
	output cdda_pkg::stat_t                     stat,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [cdda_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [cdda_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [cdda_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [cdda_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import cdda_pkg::*;

	logic [CFG_DATA_W-1:0] start_year_q;
	logic [MONTH_W-1:0]    start_month_q;
	logic [DAY_W-1:0]      start_day_q;
	logic                  pend_q;

	logic [YEAR_WIDTH-1:0] year_q;
	logic [MONTH_W-1:0]    month_q;
	logic [DAY_W-1:0]      day_q;
	logic [DAYS_W-1:0]     rem_q;
	logic [M400_W-1:0]     m400_q;
	logic                  ovf_q;
	logic [QUOT_W-1:0]     quot_q;

	logic                  out_valid_q;
	logic [OUT_YEAR_W-1:0] out_year_q;
	logic [MONTH_W-1:0]    out_month_q;
	logic [DAY_W-1:0]      out_day_q;
	logic                  out_ovf_q;

	logic                  cfg_hit;
	logic                  take;
	logic                  obusy;
	logic                  year_max;
	logic [DAY_W-1:0]      len_cur;
	logic [DAYS_W:0]       sum_dr;
	logic                  fits;
	logic [M400_W-1:0]     nxt400;
	logic [M400_W-1:0]     ylen;
	logic                  yok;
	logic [CFG_DATA_W-1:0] ld_year;
	logic [2*RECIP_W-1:0]  quot_prod;
	logic [CFG_DATA_W-1:0] year16;
	logic [CFG_DATA_W-1:0] cyc_base;
	logic [MONTH_W-1:0]    month_clamp;
	logic [DAY_W-1:0]      day_clamp;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index == CFG_START_YEAR
		|| cfg_index == CFG_START_MONTH || cfg_index == CFG_START_DAY);
	assign s_tready  = (ctrl.op == OP_TAKE) && !pend_q;
	assign take      = s_tvalid && s_tready;
	assign obusy     = out_valid_q && !m_tready;

	assign year_max = (year_q == '1);
	assign len_cur  = month_len(month_q, is_leap(m400_q));
	assign sum_dr   = {{(DAYS_W + 1 - DAY_W){1'b0}}, day_q} + {1'b0, rem_q};
	assign fits     = sum_dr <= (DAYS_W + 1)'(len_cur);
	assign nxt400   = (year_max || m400_q == CYCLE_END) ? '0 : m400_q + M400_W'(1);
	assign ylen     = YEAR_LEN + M400_W'(is_leap((month_q <= MONTH_FEB) ? m400_q : nxt400));
	assign yok      = rem_q >= DAYS_W'(ylen);

	// loaded year never exceeds 16 bits: year / 400 = (year / 16) / 25
	assign ld_year   = CFG_DATA_W'(YEAR_WIDTH'(start_year_q));
	assign quot_prod = {{RECIP_W{1'b0}}, ld_year[CFG_DATA_W-1:CFG_DATA_W-RECIP_W]}
		* {{RECIP_W{1'b0}}, RECIP_25};
	assign year16    = CFG_DATA_W'(year_q);
	assign cyc_base  = {{(CFG_DATA_W - QUOT_W){1'b0}}, quot_q} * CYCLE_LEN;

	always_comb begin
		if (start_month_q < MONTH_JAN) begin
			month_clamp = MONTH_JAN;
		end else if (start_month_q > MONTH_DEC) begin
			month_clamp = MONTH_DEC;
		end else begin
			month_clamp = start_month_q;
		end
		if (start_day_q == '0) begin
			day_clamp = DAY_W'(1);
		end else if (start_day_q > len_cur) begin
			day_clamp = len_cur;
		end else begin
			day_clamp = start_day_q;
		end
	end

	assign stat = '{pend: pend_q, take: take, fits: fits, yok: yok, obusy: obusy};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_year_q  <= RST_START_YEAR;
			start_month_q <= RST_START_MONTH;
			start_day_q   <= RST_START_DAY;
			pend_q        <= 1'b1;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_START_YEAR:  start_year_q  <= cfg_data;
					CFG_START_MONTH: start_month_q <= cfg_data[MONTH_W-1:0];
					CFG_START_DAY:   start_day_q   <= cfg_data[DAY_W-1:0];
					default: ;
				endcase
			end
			if (cfg_hit) begin
				pend_q <= 1'b1;
			end else if (ctrl.op == OP_LDINIT) begin
				pend_q <= 1'b0;
			end
			if (ctrl.op == OP_EMIT && !obusy) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_TAKE: begin
				if (take) begin
					rem_q <= s_tdata[DAYS_W-1:0];
					ovf_q <= 1'b0;
				end
			end
			OP_MSTEP: begin
				if (!fits) begin
					rem_q <= DAYS_W'(sum_dr - (DAYS_W + 1)'(len_cur) - (DAYS_W + 1)'(1));
					day_q <= DAY_W'(1);
					if (month_q >= MONTH_DEC) begin
						month_q <= MONTH_JAN;
						year_q  <= year_q + YEAR_WIDTH'(1);
						m400_q  <= nxt400;
						if (year_max) begin
							ovf_q <= 1'b1;
						end
					end else begin
						month_q <= month_q + MONTH_W'(1);
					end
				end
			end
			OP_YSTEP: begin
				if (yok) begin
					rem_q  <= rem_q - DAYS_W'(ylen);
					year_q <= year_q + YEAR_WIDTH'(1);
					m400_q <= nxt400;
					if (year_max) begin
						ovf_q <= 1'b1;
					end
				end
			end
			OP_EMIT: begin
				if (!obusy) begin
					day_q       <= DAY_W'(sum_dr);
					out_year_q  <= OUT_YEAR_W'(year_q);
					out_month_q <= month_q;
					out_day_q   <= DAY_W'(sum_dr);
					out_ovf_q   <= ovf_q;
				end
			end
			OP_LDINIT: begin
				year_q  <= YEAR_WIDTH'(start_year_q);
				quot_q  <= quot_prod[2*RECIP_W-1 -: QUOT_W];
				month_q <= month_clamp;
			end
			OP_DIVSTEP: begin
				m400_q <= M400_W'(year16 - cyc_base);
			end
			OP_CLAMP: begin
				day_q <= day_clamp;
			end
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	// m_tdata: result_year [15:0], result_month [19:16], result_day [24:20],
	// year_overflow [25], zero [31:26]
	assign m_tdata  = {6'd0, out_ovf_q, out_day_q, out_month_q, out_year_q};

endmodule

/* rtl/core/calendar_date_day_adder.sv */
`timescale 1ns / 1ps

// Each input is added by stepping Y whole years (up to 179), then M months (up to 12);
// an add within the month skips both steps and goes straight to the output. A new transfer
// is taken only once the previous result is in the output register; output stalls hold it.
// Reset or a start-date write runs a load (LOAD, DIV, CLAMP: year mod 400, then the start
// date clamp) during which no input transfer is taken. Reset date is 2000-01-01.
module calendar_date_day_adder #(
	parameter int YEAR_WIDTH = cdda_pkg::YEAR_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cdda_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cdda_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// s_tdata: days_to_add [15:0]
	input  logic [cdda_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// m_tdata: result_year [15:0], result_month [19:16], result_day [24:20],
	// year_overflow [25], zero [31:26]
	output logic [cdda_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cdda_pkg::*;

	ctrl_t ctrl;
	stat_t stat;

	cdda_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	cdda_dpath #(
		.YEAR_WIDTH (YEAR_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

/* dv/tb_calendar_date_day_adder.sv */
`timescale 1ns / 1ps

module tb_calendar_date_day_adder;
	import cdda_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED = 2'd3;
	localparam logic [4:0] DAYS_OF_MONTH [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};
	localparam int RANDOM_ITEMS = 1500;

	typedef struct {
		logic [15:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic        wrapped;
	} cal_date_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	logic [15:0] start_year_q;
	logic [3:0]  start_month_q;
	logic [4:0]  start_day_q;
	logic [15:0] date_year;
	logic [3:0]  date_month;
	logic [4:0]  date_day;

	cal_date_t pending_dates[$];
	int        mismatch_count = 0;
	bit        in_gaps_on = 1'b1;
	bit        out_stalls_on = 1'b1;

	calendar_date_day_adder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always #5 clk = ~clk;

	function automatic logic is_leap_year(input logic [15:0] y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic logic [4:0] days_in_month(input logic [15:0] y, input logic [3:0] m);
		if (m == 4'd2) begin
			return is_leap_year(y) ? 5'd29 : 5'd28;
		end
		if (m < 4'd1 || m > 4'd12) begin
			return 5'd31;
		end
		return DAYS_OF_MONTH[m - 1];
	endfunction

	function automatic void reload_date();
		logic [4:0] len;
		date_year = start_year_q;
		date_month = start_month_q;
		if (date_month < 4'd1) date_month = 4'd1;
		if (date_month > 4'd12) date_month = 4'd12;
		len = days_in_month(date_year, date_month);
		date_day = start_day_q;
		if (date_day < 5'd1) date_day = 5'd1;
		if (date_day > len) date_day = len;
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_START_YEAR:  start_year_q = val;
			CFG_START_MONTH: start_month_q = val[3:0];
			CFG_START_DAY:   start_day_q = val[4:0];
			default:         return;
		endcase
		reload_date();
	endfunction

	function automatic cal_date_t advance_date(input logic [15:0] days);
		int unsigned left;
		int unsigned len;
		cal_date_t   r;
		left = days;
		r.wrapped = 1'b0;
		len = days_in_month(date_year, date_month);
		while (date_day + left > len) begin
			left -= len - date_day + 1;
			date_day = 5'd1;
			if (date_month == 4'd12) begin
				date_month = 4'd1;
				if (date_year == 16'hFFFF) r.wrapped = 1'b1;
				date_year = date_year + 16'd1;
			end else begin
				date_month = date_month + 4'd1;
			end
			len = days_in_month(date_year, date_month);
		end
		date_day = date_day + 5'(left);
		r.year = date_year;
		r.month = date_month;
		r.day = date_day;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic send_days(input logic [15:0] days);
		int gap;
		gap = in_gaps_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= days;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_dates.push_back(advance_date(days));
	endtask

	// drop valid and hold until every pending date is back
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_dates.size() != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
	endtask

	task automatic set_start(input logic [15:0] y, input logic [15:0] m, input logic [15:0] d);
		quiesce();
		cfg_write(CFG_START_YEAR, y);
		cfg_write(CFG_START_MONTH, m);
		cfg_write(CFG_START_DAY, d);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_single(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		quiesce();
		cfg_write(idx, val);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_days();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 16'($urandom_range(0, 40));
			5, 6, 7:       return 16'($urandom_range(0, 800));
			8:             return 16'($urandom_range(0, 65535));
			default: begin
				case ($urandom_range(0, 4))
					0:       return 16'd0;
					1:       return 16'hFFFF;
					2:       return 16'd365;
					3:       return 16'd366;
					default: return 16'($urandom_range(28, 31));
				endcase
			end
		endcase
	endfunction

	task automatic randomize_start();
		logic [15:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		case ($urandom_range(0, 4))
			0:       y = 16'($urandom_range(0, 65535));
			1:       y = 16'hFFFF - 16'($urandom_range(0, 400));
			2:       y = 16'(100 * $urandom_range(1, 655) - $urandom_range(0, 4));
			3:       y = 16'($urandom_range(0, 16));
			default: y = 16'($urandom_range(1900, 2400));
		endcase
		m = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 12));
		d = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 28));
		case ($urandom_range(0, 7))
			0:       write_single(CFG_START_DAY, {11'($urandom), d});
			1:       write_single(CFG_START_MONTH, {12'($urandom), m});
			2:       write_single(CFG_UNMAPPED, 16'($urandom));
			default: set_start(y, {12'($urandom), m}, {11'($urandom), d});
		endcase
	endtask

	task automatic test_reset_date();
		send_days(16'd0);
		send_days(16'd31);
		send_days(16'd28);
		send_days(16'd1);
		send_days(16'd365);
	endtask

	task automatic test_start_clamp();
		set_start(16'd1900, 16'd2, 16'd29);
		send_days(16'd0);
		set_start(16'd2024, 16'd2, 16'd31);
		send_days(16'd0);
		set_start(16'd2023, 16'd0, 16'd0);
		send_days(16'd0);
		set_start(16'd2023, 16'd15, 16'd31);
		send_days(16'd0);
		send_days(16'd1);
		set_start(16'd2023, 16'd4, 16'd31);
		send_days(16'd0);
	endtask

	task automatic test_unmapped_index();
		set_start(16'd2023, 16'd6, 16'd15);
		send_days(16'd10);
		write_single(CFG_UNMAPPED, 16'h5AA5);
		send_days(16'd0);
		write_single(CFG_START_DAY, 16'd3);
		send_days(16'd0);
	endtask

	task automatic test_year_wrap();
		set_start(16'hFFFF, 16'd12, 16'd31);
		send_days(16'd1);
		send_days(16'd59);
		send_days(16'd0);
		set_start(16'd65400, 16'd1, 16'd1);
		send_days(16'hFFFF);
		set_start(16'd0, 16'd1, 16'd1);
		send_days(16'hFFFF);
		send_days(16'h5555);
		send_days(16'hAAAA);
	endtask

	task automatic test_random_dates();
		int sent;
		int phase_len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			randomize_start();
			in_gaps_on = ($urandom_range(0, 3) != 0);
			out_stalls_on = ($urandom_range(0, 3) != 0);
			phase_len = $urandom_range(20, 150);
			repeat (phase_len) begin
				if ($urandom_range(0, 59) == 0) quiesce();
				send_days(pick_days());
				sent++;
			end
		end
		quiesce();
	endtask

	initial begin : result_sink
		int stall;
		forever begin
			stall = out_stalls_on ? $urandom_range(0, 8) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin : result_check
		cal_date_t exp_date;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_dates.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", m_tdata));
			end else begin
				exp_date = pending_dates.pop_front();
				if (m_tdata[15:0] !== exp_date.year)
					report_mismatch($sformatf("year got %0d exp %0d",
						m_tdata[15:0], exp_date.year));
				if (m_tdata[19:16] !== exp_date.month)
					report_mismatch($sformatf("month got %0d exp %0d",
						m_tdata[19:16], exp_date.month));
				if (m_tdata[24:20] !== exp_date.day)
					report_mismatch($sformatf("day got %0d exp %0d",
						m_tdata[24:20], exp_date.day));
				if (m_tdata[25] !== exp_date.wrapped)
					report_mismatch($sformatf("year_overflow got %b exp %b",
						m_tdata[25], exp_date.wrapped));
				if (m_tdata[31:26] !== 6'd0)
					report_mismatch($sformatf("pad bits got %b", m_tdata[31:26]));
			end
		end
	end

	initial begin
		#20_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		start_year_q = 16'(RST_START_YEAR);
		start_month_q = RST_START_MONTH;
		start_day_q = RST_START_DAY;
		reload_date();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_date();
		test_start_clamp();
		test_unmapped_index();
		test_year_wrap();
		test_random_dates();
		repeat (250) @(posedge clk);
		if (mismatch_count == 0 && pending_dates.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
